// File: rtl/rmsq_pkg.sv
// shared constants, types and command codes of the rms mapping quality accumulator
package rmsq_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int SUM_W       = 40;
  localparam int FLAG_W      = 16;
  localparam int QUAL_W      = 8;
  localparam int OUT_CNT_W   = 24;
  localparam int SQ_W        = 2 * QUAL_W;
  localparam int SQRT_STEPS  = QUAL_W;
  localparam int SUB_W       = (COUNT_WIDTH + 1 > 2 * QUAL_W - 5) ?
                               COUNT_WIDTH + 1 : 2 * QUAL_W - 5;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int CMP_W       = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [FLAG_W-1:0] FLAG_SECONDARY = 16'h0100;
  localparam logic [FLAG_W-1:0] FLAG_QCFAIL    = 16'h0200;
  localparam logic [FLAG_W-1:0] FLAG_DUPLICATE = 16'h0400;
  localparam logic [FLAG_W-1:0] FLAG_SKIP_MASK = FLAG_SECONDARY | FLAG_QCFAIL | FLAG_DUPLICATE;

  typedef struct packed {
    logic                   start;
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] count;
  } rmsq_job_t;

  typedef struct packed {
    logic              done;
    logic [QUAL_W-1:0] root;
  } rmsq_res_t;

  function automatic logic [OUT_CNT_W-1:0] sat_out_count(input logic [COUNT_WIDTH-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext > CMP_W'({OUT_CNT_W{1'b1}})) begin
      return {OUT_CNT_W{1'b1}};
    end
    return ext[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: rtl/rmsq_chan_if.sv
// request channels of the accumulator: read/finish input and report output
interface rmsq_in_if;
  import rmsq_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [FLAG_W-1:0] read_flags;
  logic [QUAL_W-1:0] map_quality;
  modport source (output valid, command, read_flags, map_quality, input ready);
  modport sink   (input valid, command, read_flags, map_quality, output ready);
endinterface

interface rmsq_out_if;
  import rmsq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [QUAL_W-1:0]    rms_quality;
  logic [OUT_CNT_W-1:0] zero_quality_count;
  logic                 region_empty;
  modport source (output valid, rms_quality, zero_quality_count, region_empty, input ready);
  modport sink   (input valid, rms_quality, zero_quality_count, region_empty, output ready);
endinterface

// File: rtl/rms_mapping_quality_accumulator_unit.sv
// top level of the rms mapping quality accumulator
// accumulate requests: one per cycle, ready stays high, no result request
// finish request: 40 restoring divide steps, then 8 square root steps on the shared subtractor;
//   the square root is skipped and the root saturates when the mean reaches 2^16, then report valid
// empty finish: skips the engine; input ready again once the report is loaded into the output register
// synchronous active-low reset clears accumulators, sequencer and output valid
module rms_mapping_quality_accumulator_unit (
  input logic clk,
  input logic rst_n,
  rmsq_in_if.sink    in_chan,
  rmsq_out_if.source out_chan
);
  import rmsq_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] read_count_r, read_count_nxt;
  logic [COUNT_WIDTH-1:0] zero_count_r, zero_count_nxt;

  // finished report waiting for the output register
  logic [QUAL_W-1:0]    res_root_r, res_root_nxt;
  logic [OUT_CNT_W-1:0] res_zero_r, res_zero_nxt;
  logic                 res_empty_r, res_empty_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [QUAL_W-1:0]    out_root_r, out_root_nxt;
  logic [OUT_CNT_W-1:0] out_zero_r, out_zero_nxt;
  logic                 out_empty_r, out_empty_nxt;

  logic            in_fire;
  logic            read_counted;
  logic [SQ_W-1:0] qual_sq;
  logic [SUM_W:0]  sum_wide;
  logic            out_free;

  rmsq_job_t job;
  rmsq_res_t res;

  assign in_chan.ready = (state_r == T_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  // reads that are secondary, qc-fail or duplicate are dropped
  assign read_counted  = in_fire && (in_chan.command == CMD_ACCUM) &&
                         ((in_chan.read_flags & FLAG_SKIP_MASK) == '0);
  assign qual_sq       = SQ_W'(in_chan.map_quality) * SQ_W'(in_chan.map_quality);
  assign sum_wide      = {1'b0, sum_r} + (SUM_W + 1)'(qual_sq);
  assign out_free      = !out_valid_r || out_chan.ready;

  // start the divide/root engine on a finish with at least one counted read
  assign job.start = in_fire && (in_chan.command == CMD_FINISH) && (read_count_r != '0);
  assign job.sum   = sum_r;
  assign job.count = read_count_r;

  rmsq_root_unit u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .res   (res)
  );

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    read_count_nxt = read_count_r;
    zero_count_nxt = zero_count_r;
    res_root_nxt   = res_root_r;
    res_zero_nxt   = res_zero_r;
    res_empty_nxt  = res_empty_r;
    out_valid_nxt  = out_valid_r;
    out_root_nxt   = out_root_r;
    out_zero_nxt   = out_zero_r;
    out_empty_nxt  = out_empty_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // saturating accumulators
    if (read_counted) begin
      sum_nxt = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      if (read_count_r != {COUNT_WIDTH{1'b1}}) begin
        read_count_nxt = read_count_r + 1'b1;
      end
      if ((in_chan.map_quality == '0) && (zero_count_r != {COUNT_WIDTH{1'b1}})) begin
        zero_count_nxt = zero_count_r + 1'b1;
      end
    end

    unique case (state_r)
      T_IDLE: begin
        if (in_fire && (in_chan.command == CMD_FINISH)) begin
          sum_nxt        = '0;
          read_count_nxt = '0;
          zero_count_nxt = '0;
          if (read_count_r == '0) begin
            // empty region: report directly
            res_root_nxt  = '0;
            res_zero_nxt  = '0;
            res_empty_nxt = 1'b1;
            state_nxt     = T_HOLD;
          end else begin
            res_zero_nxt  = sat_out_count(zero_count_r);
            res_empty_nxt = 1'b0;
            state_nxt     = T_RUN;
          end
        end
      end
      T_RUN: begin
        if (res.done) begin
          res_root_nxt = res.root;
          state_nxt    = T_HOLD;
        end
      end
      T_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_root_r;
          out_zero_nxt  = res_zero_r;
          out_empty_nxt = res_empty_r;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      sum_r        <= '0;
      read_count_r <= '0;
      zero_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      read_count_r <= read_count_nxt;
      zero_count_r <= zero_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_root_r  <= res_root_nxt;
    res_zero_r  <= res_zero_nxt;
    res_empty_r <= res_empty_nxt;
    out_root_r  <= out_root_nxt;
    out_zero_r  <= out_zero_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.rms_quality        = out_root_r;
  assign out_chan.zero_quality_count = out_zero_r;
  assign out_chan.region_empty       = out_empty_r;

  // zero-quality reads are a subset of counted reads
  a_zero_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    zero_count_r <= read_count_r)
    else $error("zero-quality count exceeds read count");

  // the engine only finishes while a finish request is in flight
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == T_RUN))
    else $error("root engine finished outside a finish request");

  // a finish clears every accumulator
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.command == CMD_FINISH)) |=>
      (sum_r == '0) && (read_count_r == '0) && (zero_count_r == '0))
    else $error("accumulators not cleared by finish");

  // a counted read below saturation bumps the read count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (read_counted && (read_count_r != {COUNT_WIDTH{1'b1}})) |=>
      (read_count_r == $past(read_count_r) + 1'b1))
    else $error("read count did not advance");

  // an empty finish goes straight to the report with the empty flag set
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.command == CMD_FINISH) && (read_count_r == '0)) |=>
      ((state_r == T_HOLD) && res_empty_r && (res_root_r == '0)))
    else $error("empty region not reported as empty");

endmodule

// File: rtl/rmsq_root_unit.sv
// divide-then-square-root sequencer around one shared compare/subtract unit
module rmsq_root_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  rmsq_pkg::rmsq_job_t job,
  output rmsq_pkg::rmsq_res_t res
);
  import rmsq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [STEP_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]       dvd_r, dvd_nxt;
  logic [COUNT_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [SUB_W-2:0]       rem_r, rem_nxt;
  logic [SQ_W-1:0]        sv_r, sv_nxt;
  logic [QUAL_W-1:0]      rt_r, rt_nxt;

  logic [SUB_W-1:0] op_a, op_b;
  logic [SUB_W:0]   diff_full;
  logic             ge;
  logic [SUB_W-2:0] rem_step;
  logic [SUM_W-1:0] quot;

  // shared compare/subtract unit
  always_comb begin
    if (state_r == S_SQRT) begin
      op_a = SUB_W'({rem_r[SUB_W-4:0], sv_r[SQ_W-1 -: 2]});
      op_b = SUB_W'({rt_r, 2'b01});
    end else begin
      op_a = {rem_r, dvd_r[SUM_W-1]};
      op_b = SUB_W'(dvs_r);
    end
    diff_full = {1'b0, op_a} - {1'b0, op_b};
    ge        = ~diff_full[SUB_W];
    rem_step  = ge ? diff_full[SUB_W-2:0] : op_a[SUB_W-2:0];
    quot      = {dvd_r[SUM_W-2:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    sv_nxt    = sv_r;
    rt_nxt    = rt_r;
    unique case (state_r)
      S_IDLE: begin
        if (job.start) begin
          dvd_nxt   = job.sum;
          dvs_nxt   = job.count;
          rem_nxt   = '0;
          cnt_nxt   = STEP_W'(SUM_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt = quot;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // mean of 2^16 or more has a root above the 8-bit range
          if (quot[SUM_W-1:SQ_W] != '0) begin
            rt_nxt    = '1;
            state_nxt = S_DONE;
          end else begin
            sv_nxt    = quot[SQ_W-1:0];
            rt_nxt    = '0;
            rem_nxt   = '0;
            cnt_nxt   = STEP_W'(SQRT_STEPS - 1);
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        rem_nxt = rem_step;
        rt_nxt  = {rt_r[QUAL_W-2:0], ge};
        sv_nxt  = {sv_r[SQ_W-3:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    sv_r  <= sv_nxt;
    rt_r  <= rt_nxt;
  end

  assign res.done = (state_r == S_DONE);
  assign res.root = rt_r;

endmodule
